[src/vum_pkg.sv]
// Shared types, codes and the element widening function of the vector unpack unit.
// No dependencies; every other file imports it.
`default_nettype none

package vum_pkg;

   localparam int unsigned LANES    = 4;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned CSR_IDX_W = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MASK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_3 = 3'd5;

   localparam logic [3:0] FMT_V4_5 = 4'hF;

   typedef enum logic [1:0] {
      WSEL_32  = 2'd0,
      WSEL_16  = 2'd1,
      WSEL_8   = 2'd2,
      WSEL_BAD = 2'd3
   } wsel_type;

   typedef enum logic [1:0] {
      VN_S  = 2'd0,
      VN_V2 = 2'd1,
      VN_V3 = 2'd2,
      VN_V4 = 2'd3
   } vnum_type;

   typedef enum logic [1:0] {
      SEL_DATA = 2'd0,
      SEL_ROW  = 2'd1,
      SEL_COL  = 2'd2,
      SEL_NONE = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      ADD_DIRECT     = 2'd0,
      ADD_OFFSET     = 2'd1,
      ADD_ACCUM      = 2'd2,
      ADD_DIRECT_ALT = 2'd3
   } add_type;

   // V4-5 field masks
   localparam logic [15:0] V45_R = 16'h001F;
   localparam logic [15:0] V45_G = 16'h03E0;
   localparam logic [15:0] V45_B = 16'h7C00;
   localparam logic [15:0] V45_A = 16'h8000;

   typedef logic [LANES-1:0][WORD_W-1:0] vec_type;

   typedef struct packed {
      logic bad;
      logic direct_only;
   } dec_type;

   typedef struct packed {
      logic       en;
      logic       load;
      logic       direct_only;
      add_type    add_mode;
      sel_type    sel;
   } lane_ctl_type;

   typedef struct packed {
      vec_type          words;
      logic [LANES-1:0] we;
      logic             bad;
   } rsp_type;

   function automatic logic [WORD_W-1:0] widen(input logic [WORD_W-1:0] raw,
                                               input wsel_type wsel,
                                               input logic sgn);
      logic [WORD_W-1:0] v;
      v = raw;
      unique case (wsel)
         WSEL_16: v = {{16{sgn & raw[15]}}, raw[15:0]};
         WSEL_8:  v = {{24{sgn & raw[7]}}, raw[7:0]};
         WSEL_32, WSEL_BAD: v = raw;
         default: v = raw;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[src/vum_decode.sv]
// Format decode: widens the raw elements, or splits a V4-5 half word, and spreads them over the four lanes.
// Depends on vum_pkg.
`default_nettype none

module vum_decode
   import vum_pkg::*;
(
   input  wire logic [3:0]        format,
   input  wire logic              is_signed,
   input  wire logic [WORD_W-1:0] comp_x,
   input  wire logic [WORD_W-1:0] comp_y,
   input  wire logic [WORD_W-1:0] comp_z,
   input  wire logic [WORD_W-1:0] comp_w,
   output vec_type                data,
   output dec_type                dec
);

   wsel_type          wsel;
   vnum_type          vn;
   logic [15:0]       half;
   logic [WORD_W-1:0] e0, e1, e2, e3;

   assign wsel = wsel_type'(format[1:0]);
   assign vn   = vnum_type'(format[3:2]);
   assign half = comp_x[15:0];

   assign e0 = widen(comp_x, wsel, is_signed);
   assign e1 = widen(comp_y, wsel, is_signed);
   assign e2 = widen(comp_z, wsel, is_signed);
   assign e3 = widen(comp_w, wsel, is_signed);

   always_comb begin
      dec.direct_only = (format == FMT_V4_5);
      dec.bad         = (wsel == WSEL_BAD) && (format != FMT_V4_5);
      if (format == FMT_V4_5) begin
         data[0] = WORD_W'({half & V45_R, 3'b000});
         data[1] = WORD_W'((half & V45_G) >> 2);
         data[2] = WORD_W'((half & V45_B) >> 7);
         data[3] = WORD_W'((half & V45_A) >> 8);
      end else begin
         unique case (vn)
            VN_S: begin
               data[0] = e0; data[1] = e0; data[2] = e0; data[3] = e0;
            end
            // V2: Z takes X again, W takes Y again
            VN_V2: begin
               data[0] = e0; data[1] = e1; data[2] = e0; data[3] = e1;
            end
            VN_V3, VN_V4: begin
               data[0] = e0; data[1] = e1; data[2] = e2; data[3] = e3;
            end
            default: begin
               data[0] = e0; data[1] = e1; data[2] = e2; data[3] = e3;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[src/vum_lane.sv]
// One component lane: holds its row register and applies the write selection.
// Depends on vum_pkg.
`default_nettype none

module vum_lane
   import vum_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lane_ctl_type      ctl,
   input  wire logic [WORD_W-1:0] data,
   input  wire logic [WORD_W-1:0] col,
   output logic [WORD_W-1:0]      result,
   output logic                   we
);

   logic [WORD_W-1:0] row_ff, row_in;
   logic [WORD_W-1:0] sum;
   logic              accum;

   assign sum   = data + row_ff;
   assign accum = (ctl.sel == SEL_DATA) && !ctl.direct_only && (ctl.add_mode == ADD_ACCUM);

   always_comb begin
      result = '0;
      we     = 1'b1;
      unique case (ctl.sel)
         SEL_DATA: begin
            if (ctl.direct_only) begin
               result = data;
            end else begin
               unique case (ctl.add_mode)
                  ADD_OFFSET, ADD_ACCUM:      result = sum;
                  ADD_DIRECT, ADD_DIRECT_ALT: result = data;
                  default:                    result = data;
               endcase
            end
         end
         SEL_ROW:  result = row_ff;
         SEL_COL:  result = col;
         SEL_NONE: we = 1'b0;
         default:  we = 1'b0;
      endcase
   end

   always_comb begin
      row_in = row_ff;
      priority if (ctl.load) begin
         row_in = data;
      end else if (ctl.en && accum) begin
         row_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

[src/vum_skid.sv]
// Two-entry result buffer: output register plus skid register.
// Depends on vum_pkg.
`default_nettype none

module vum_skid
   import vum_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_word,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_word
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    push, pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         priority if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = in_word;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         // park the word in the skid stage while the output word waits
         if (out_valid_ff) begin
            skid_in       = in_word;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = in_word;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

[src/vector_unpack_mask_unit.sv]
// Top level of the vector unpack unit with write mask.
// Depends on vum_pkg, vum_decode, vum_lane and vum_skid.
`default_nettype none

// Takes packed vector or row-load words and returns one result word per item.
// An accepted item's result is registered in the output buffer, and a new item
// may enter every cycle while req_ready is high: the four lanes each read, add
// and update their own row register as the item is accepted, so an accumulate
// item is complete before the next arrives. A two-entry output buffer keeps
// req_ready high while one result waits on rsp_ready; req_ready drops only when
// both entries are full. csr_ready is always high; writes are meant for an idle block.
module vector_unpack_mask_unit
   import vum_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_mode,
   input  wire logic [3:0]           req_format,
   input  wire logic                 req_is_signed,
   input  wire logic                 req_use_mask,
   input  wire logic [1:0]           req_cycle,
   input  wire logic [WORD_W-1:0]    req_comp_x,
   input  wire logic [WORD_W-1:0]    req_comp_y,
   input  wire logic [WORD_W-1:0]    req_comp_z,
   input  wire logic [WORD_W-1:0]    req_comp_w,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [WORD_W-1:0]         rsp_out_x,
   output logic [WORD_W-1:0]         rsp_out_y,
   output logic [WORD_W-1:0]         rsp_out_z,
   output logic [WORD_W-1:0]         rsp_out_w,
   output logic [LANES-1:0]          rsp_write_enable,
   output logic                      rsp_bad_format
);

   logic [WORD_W-1:0]              mask_ff, mask_in;
   add_type                        add_ff, add_in;
   logic [LANES-1:0][WORD_W-1:0]   col_ff, col_in;

   vec_type           data, raw, lane_res;
   dec_type           dec;
   logic              accept;
   logic [7:0]        mask_byte;
   logic [LANES-1:0]  lane_we;
   lane_ctl_type      ctl [LANES];
   rsp_type           rsp_in, rsp_out;
   logic              active;

   assign csr_ready = 1'b1;

   always_comb begin
      mask_in = mask_ff;
      add_in  = add_ff;
      col_in  = col_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MASK:  mask_in   = csr_data;
            CSR_ADD:   add_in    = add_type'(csr_data[1:0]);
            CSR_COL_0: col_in[0] = csr_data;
            CSR_COL_1: col_in[1] = csr_data;
            CSR_COL_2: col_in[2] = csr_data;
            CSR_COL_3: col_in[3] = csr_data;
            default:   mask_in   = mask_ff;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         add_ff  <= ADD_DIRECT;
         col_ff  <= '0;
      end else begin
         mask_ff <= mask_in;
         add_ff  <= add_in;
         col_ff  <= col_in;
      end
   end

   vum_decode u_decode (
      .format    (req_format),
      .is_signed (req_is_signed),
      .comp_x    (req_comp_x),
      .comp_y    (req_comp_y),
      .comp_z    (req_comp_z),
      .comp_w    (req_comp_w),
      .data      (data),
      .dec       (dec)
   );

   assign accept    = req_valid && req_ready;
   assign mask_byte = mask_ff[{req_cycle, 3'b000} +: 8];
   assign raw       = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};
   assign active    = !req_mode && !dec.bad;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      always_comb begin
         ctl[i].en          = accept && active;
         ctl[i].load        = accept && req_mode;
         ctl[i].direct_only = dec.direct_only;
         ctl[i].add_mode    = add_ff;
         ctl[i].sel         = req_use_mask ? sel_type'(mask_byte[2*i +: 2]) : SEL_DATA;
      end

      vum_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[i]),
         .data   (req_mode ? raw[i] : data[i]),
         .col    (col_ff[req_cycle]),
         .result (lane_res[i]),
         .we     (lane_we[i])
      );

      // load and bad-format items give all-zero words
      assign rsp_in.words[i] = active ? lane_res[i] : '0;
   end

   assign rsp_in.we  = active ? lane_we : '0;
   assign rsp_in.bad = !req_mode && dec.bad;

   vum_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (rsp_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_out)
   );

   assign rsp_out_x        = rsp_out.words[0];
   assign rsp_out_y        = rsp_out.words[1];
   assign rsp_out_z        = rsp_out.words[2];
   assign rsp_out_w        = rsp_out.words[3];
   assign rsp_write_enable = rsp_out.we;
   assign rsp_bad_format   = rsp_out.bad;

endmodule

`default_nettype wire

[src/vum_checker.sv]
// Port-level checks for vector_unpack_mask_unit, bound to the top level.
// Depends on vum_pkg.
`default_nettype none

module vum_checker
   import vum_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [WORD_W-1:0]    rsp_out_x,
   input wire logic [WORD_W-1:0]    rsp_out_y,
   input wire logic [WORD_W-1:0]    rsp_out_z,
   input wire logic [WORD_W-1:0]    rsp_out_w,
   input wire logic [LANES-1:0]     rsp_write_enable,
   input wire logic                 rsp_bad_format
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("empty buffer refuses a word");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_z) && $stable(rsp_out_w) && $stable(rsp_write_enable)
         && $stable(rsp_bad_format))
      else $error("stalled result word changed");

   a_bad_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_format |-> rsp_write_enable == '0 && rsp_out_x == '0
         && rsp_out_y == '0 && rsp_out_z == '0 && rsp_out_w == '0)
      else $error("bad format word carries data");

   a_nowrite_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable[0] |-> rsp_out_x == '0)
      else $error("unwritten X component not zero");

endmodule

bind vector_unpack_mask_unit vum_checker u_vum_checker (.*);

`default_nettype wire

[bench/tb_vector_unpack_mask_unit.sv]
// Self-checking bench for vector_unpack_mask_unit: directed and random words on req_,
// predicted results compared with rsp_ in order, register writes between phases.
// Depends on vum_pkg and the RTL under src only.
`default_nettype none

module tb_vector_unpack_mask_unit;
   import vum_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned PHASE_ITEMS = 135;

   typedef struct packed {
      logic                         mode;
      logic [3:0]                   format;
      logic                         is_signed;
      logic                         use_mask;
      logic [1:0]                   cycle;
      logic [LANES-1:0][WORD_W-1:0] comp;
   } unpack_item_type;

   typedef struct packed {
      logic [LANES-1:0][WORD_W-1:0] word;
      logic [LANES-1:0]             we;
      logic                         bad;
   } unpack_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_data;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [3:0]           req_format;
   logic                 req_is_signed;
   logic                 req_use_mask;
   logic [1:0]           req_cycle;
   logic [WORD_W-1:0]    req_comp_x;
   logic [WORD_W-1:0]    req_comp_y;
   logic [WORD_W-1:0]    req_comp_z;
   logic [WORD_W-1:0]    req_comp_w;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [WORD_W-1:0]    rsp_out_x;
   logic [WORD_W-1:0]    rsp_out_y;
   logic [WORD_W-1:0]    rsp_out_z;
   logic [WORD_W-1:0]    rsp_out_w;
   logic [LANES-1:0]     rsp_write_enable;
   logic                 rsp_bad_format;

   // shadow of the block's registers and row state
   logic [WORD_W-1:0] mask_reg;
   add_type           add_reg;
   logic [WORD_W-1:0] col_reg [LANES];
   logic [WORD_W-1:0] row_reg [LANES];

   unpack_result_type expected_q [$];
   int unsigned       error_count;
   int unsigned       cycle_count;
   bit                quiet;

   vector_unpack_mask_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_format       (req_format),
      .req_is_signed    (req_is_signed),
      .req_use_mask     (req_use_mask),
      .req_cycle        (req_cycle),
      .req_comp_x       (req_comp_x),
      .req_comp_y       (req_comp_y),
      .req_comp_z       (req_comp_z),
      .req_comp_w       (req_comp_w),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_w        (rsp_out_w),
      .rsp_write_enable (rsp_write_enable),
      .rsp_bad_format   (rsp_bad_format)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   function automatic unpack_result_type predict_unpack(input unpack_item_type it);
      unpack_result_type r;
      logic [WORD_W-1:0] elem [LANES];
      logic [WORD_W-1:0] data [LANES];
      logic [WORD_W-1:0] half;
      wsel_type          ws;
      vnum_type          vn;
      sel_type           sel;
      logic              direct;
      r = '0;
      if (it.mode) begin
         for (int i = 0; i < LANES; i++) row_reg[i] = it.comp[i];
         return r;
      end
      ws = wsel_type'(it.format[1:0]);
      vn = vnum_type'(it.format[3:2]);
      direct = (it.format == FMT_V4_5);
      if (direct) begin
         half = {16'h0000, it.comp[0][15:0]};
         data[0] = (half & {16'h0000, V45_R}) << 3;
         data[1] = (half & {16'h0000, V45_G}) >> 2;
         data[2] = (half & {16'h0000, V45_B}) >> 7;
         data[3] = (half & {16'h0000, V45_A}) >> 8;
      end else if (ws == WSEL_BAD) begin
         r.bad = 1'b1;
         return r;
      end else begin
         for (int i = 0; i < LANES; i++) begin
            if (ws == WSEL_16)
               elem[i] = it.is_signed ? 32'($signed(it.comp[i][15:0]))
                                      : 32'(it.comp[i][15:0]);
            else if (ws == WSEL_8)
               elem[i] = it.is_signed ? 32'($signed(it.comp[i][7:0]))
                                      : 32'(it.comp[i][7:0]);
            else
               elem[i] = it.comp[i];
         end
         case (vn)
            VN_S: begin
               for (int i = 0; i < LANES; i++) data[i] = elem[0];
            end
            VN_V2: begin
               data[0] = elem[0];
               data[1] = elem[1];
               data[2] = elem[0];
               data[3] = elem[1];
            end
            default: begin
               for (int i = 0; i < LANES; i++) data[i] = elem[i];
            end
         endcase
      end
      for (int i = 0; i < LANES; i++) begin
         sel = it.use_mask ? sel_type'(mask_reg[int'(it.cycle) * 8 + i * 2 +: 2]) : SEL_DATA;
         r.we[i] = 1'b1;
         case (sel)
            SEL_DATA: begin
               if (direct || add_reg == ADD_DIRECT || add_reg == ADD_DIRECT_ALT) begin
                  r.word[i] = data[i];
               end else if (add_reg == ADD_OFFSET) begin
                  r.word[i] = data[i] + row_reg[i];
               end else begin
                  row_reg[i] = row_reg[i] + data[i];
                  r.word[i] = row_reg[i];
               end
            end
            SEL_ROW: r.word[i] = row_reg[i];
            SEL_COL: r.word[i] = col_reg[it.cycle];
            default: begin
               r.word[i] = '0;
               r.we[i] = 1'b0;
            end
         endcase
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   // observe register writes, accepted words and results at the rising edge
   always @(posedge clock) begin
      unpack_item_type   it;
      unpack_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MASK:  mask_reg = csr_data;
               CSR_ADD:   add_reg = add_type'(csr_data[1:0]);
               CSR_COL_0: col_reg[0] = csr_data;
               CSR_COL_1: col_reg[1] = csr_data;
               CSR_COL_2: col_reg[2] = csr_data;
               CSR_COL_3: col_reg[3] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            it.mode      = req_mode;
            it.format    = req_format;
            it.is_signed = req_is_signed;
            it.use_mask  = req_use_mask;
            it.cycle     = req_cycle;
            it.comp      = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};
            expected_q.push_back(predict_unpack(it));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result word with no expectation pending");
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("out_x", want.word[0], rsp_out_x);
               check_field("out_y", want.word[1], rsp_out_y);
               check_field("out_z", want.word[2], rsp_out_z);
               check_field("out_w", want.word[3], rsp_out_w);
               check_field("write_enable", 32'(want.we), 32'(rsp_write_enable));
               check_field("bad_format", 32'(want.bad), 32'(rsp_bad_format));
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return $urandom & 32'h0000_807F;
         3: return $urandom | 32'h0000_8080;
         default: return $urandom;
      endcase
   endfunction

   // back-pressure on the result side
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input unpack_item_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode      = it.mode;
      req_format    = it.format;
      req_is_signed = it.is_signed;
      req_use_mask  = it.use_mask;
      req_cycle     = it.cycle;
      req_comp_x    = it.comp[0];
      req_comp_y    = it.comp[1];
      req_comp_z    = it.comp[2];
      req_comp_w    = it.comp[3];
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic unpack_item_type make_unpack(input logic [3:0] fmt, input logic sgn,
                                                   input logic msk, input logic [1:0] cyc,
                                                   input logic [WORD_W-1:0] x, y, z, w);
      unpack_item_type it;
      it.mode      = 1'b0;
      it.format    = fmt;
      it.is_signed = sgn;
      it.use_mask  = msk;
      it.cycle     = cyc;
      it.comp      = {w, z, y, x};
      return it;
   endfunction

   function automatic unpack_item_type make_load(input logic [WORD_W-1:0] x, y, z, w);
      unpack_item_type it;
      it = make_unpack(4'h0, 1'b0, 1'b0, 2'd0, x, y, z, w);
      it.mode = 1'b1;
      return it;
   endfunction

   // drop valid, let every expected word arrive, then let the pipeline settle
   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(input logic [WORD_W-1:0] mask, input add_type add,
                             input logic [WORD_W-1:0] c0, c1, c2, c3);
      wait_idle();
      write_reg(CSR_MASK, mask);
      write_reg(CSR_ADD, 32'(add));
      write_reg(CSR_COL_0, c0);
      write_reg(CSR_COL_1, c1);
      write_reg(CSR_COL_2, c2);
      write_reg(CSR_COL_3, c3);
   endtask

   // ---------------------------------------------------------------- tests

   // every format once, narrow elements on both sign boundaries
   task automatic test_formats();
      logic [3:0] fmt;
      for (int f = 0; f < 16; f++) begin
         fmt = 4'(f);
         send_item(make_unpack(fmt, fmt[2] ^ fmt[0], 1'b0, 2'd0,
                               32'hFFFF_8080, 32'h7FFF_7F7F, 32'h0123_FFFF, 32'hFEDC_0001));
      end
   endtask

   // selector per lane: data, row, column, none; then add modes and V4-5
   task automatic test_masking();
      set_config(32'hE4E4_E4E4, ADD_DIRECT, 32'h1111_1111, 32'h2222_2222,
                 32'h3333_3333, 32'hFFFF_FFFF);
      send_item(make_load(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF));
      for (int c = 0; c < 4; c++)
         send_item(make_unpack(4'hC, 1'b0, 1'b1, 2'(c),
                               32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hDEAD_BEEF, 32'h0000_0000));
      set_config(32'h0000_0000, ADD_OFFSET, '0, '0, '0, '0);
      send_item(make_unpack(4'hC, 1'b0, 1'b0, 2'd3,
                            32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001));
      set_config(32'hFFFF_FFFF, ADD_ACCUM, '1, '1, '1, '1);
      // all lanes off, then accumulate with wrap past 2^32
      send_item(make_unpack(4'hC, 1'b1, 1'b1, 2'd2, '1, '1, '1, '1));
      send_item(make_unpack(4'hC, 1'b1, 1'b0, 2'd2,
                            32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0001));
      send_item(make_unpack(4'hD, 1'b1, 1'b0, 2'd1, 32'h0000_FFFF, 32'h0000_8000, '0, '0));
      // V4-5 ignores accumulate
      send_item(make_unpack(FMT_V4_5, 1'b1, 1'b0, 2'd0, 32'hFFFF_FFFF, '0, '0, '0));
      send_item(make_unpack(FMT_V4_5, 1'b0, 1'b0, 2'd0, 32'h0000_7FFF, '1, '1, '1));
      set_config(32'hFFFF_FFFF, ADD_DIRECT_ALT, '0, '0, '0, '0);
      send_item(make_unpack(4'h4, 1'b0, 1'b0, 2'd0, '1, '0, '1, '0));
   endtask

   task automatic test_random(input int unsigned phase);
      unpack_item_type   it;
      logic [WORD_W-1:0] mask;
      case (phase)
         0: set_config('0, ADD_DIRECT, '0, '0, '0, '0);
         1: set_config('1, ADD_DIRECT_ALT, '1, '1, '1, '1);
         default: begin
            case ($urandom_range(0, 3))
               0: mask = '0;
               1: mask = 32'h0000_0000 | ($urandom & 32'h5555_5555);
               2: mask = 32'hAAAA_AAAA & $urandom;
               default: mask = $urandom;
            endcase
            set_config(mask, add_type'($urandom_range(0, 3)), rand_word(), rand_word(),
                       rand_word(), rand_word());
         end
      endcase
      quiet = (phase == 2 || phase == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            it = make_load(rand_word(), rand_word(), rand_word(), rand_word());
            // the block ignores these fields on a load; vary them anyway
            it.format    = 4'($urandom_range(0, 15));
            it.use_mask  = 1'($urandom_range(0, 1));
            it.cycle     = 2'($urandom_range(0, 3));
            it.is_signed = 1'($urandom_range(0, 1));
         end else begin
            it = make_unpack(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             rand_word(), rand_word(), rand_word(), rand_word());
         end
         send_item(it);
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = CSR_MASK;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_mode      = 1'b0;
      req_format    = '0;
      req_is_signed = 1'b0;
      req_use_mask  = 1'b0;
      req_cycle     = '0;
      req_comp_x    = '0;
      req_comp_y    = '0;
      req_comp_z    = '0;
      req_comp_w    = '0;
      error_count   = 0;
      cycle_count   = 0;
      quiet         = 1'b0;
      mask_reg      = '0;
      add_reg       = ADD_DIRECT;
      for (int i = 0; i < LANES; i++) begin
         col_reg[i] = '0;
         row_reg[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_formats();
      test_masking();
      for (int p = 0; p < 6; p++) test_random(p);

      wait_idle();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
src/vum_pkg.sv
src/vum_decode.sv
src/vum_lane.sv
src/vum_skid.sv
src/vector_unpack_mask_unit.sv
src/vum_checker.sv
bench/tb_vector_unpack_mask_unit.sv
